// ===== rtl/gps_subtime_matcher_macros.svh =====
// Assertion helpers for the GPS sub-second matcher.
// Both forms sample on the rising edge of clock and are off during reset.
`ifndef GPS_SUBTIME_MATCHER_MACROS_SVH
`define GPS_SUBTIME_MATCHER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GSM_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gps_subtime_matcher: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define GSM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gps_subtime_matcher: next-cycle check failed");

`endif

// ===== rtl/gsm_pkg.sv =====
package gsm_pkg;

   localparam int QUEUE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam int SEC_W    = 32;
   localparam int SUB_W    = 24;
   localparam int WIN_W    = 24;
   localparam int STORED_W = 11;
   // event time in 100 ns units: microseconds * 10 of a 24-bit field
   localparam int EV_W     = 28;
   localparam int DIFF_W   = 30;
   localparam int OFF_W    = 31;

   localparam int SUBS_PER_SECOND = 10000000;
   localparam logic [WIN_W-1:0] WINDOW_RESET = 24'd500000;

   localparam logic GSM_OP_PUSH  = 1'b0;
   localparam logic GSM_OP_MATCH = 1'b1;

   typedef logic [CNT_W-1:0]          gsm_count_type;
   typedef logic [IDX_W-1:0]          gsm_index_type;
   typedef logic [STORED_W-1:0]       gsm_stored_type;
   typedef logic [EV_W-1:0]           gsm_event_type;
   typedef logic signed [DIFF_W-1:0]  gsm_diff_type;
   typedef logic signed [OFF_W-1:0]   gsm_off_type;

   typedef struct packed {
      logic [SEC_W-1:0] sec;
      logic [SUB_W-1:0] sub;
   } gsm_entry_type;

   // load: write the new stamp into the cell at position count
   // rotate: move every held entry one place toward the head, head wraps to the tail
   // shift: move every entry one place toward the head, head is dropped
   typedef struct packed {
      logic          load;
      logic          rotate;
      logic          shift;
      gsm_count_type count;
   } gsm_chain_ctrl_type;

   typedef enum logic [1:0] {
      GSM_IDLE,
      GSM_DIFF,
      GSM_PROD,
      GSM_DECIDE
   } gsm_state_type;

endpackage

// ===== rtl/gps_subtime_matcher.sv =====
// GPS sub-second matcher.
// req channel (valid/ready): opcode 0 pushes a GPS stamp (seconds, 100 ns
// sub-second count) onto the tail of a 1024-entry queue; opcode 1 matches an
// event (seconds, microseconds) against the queue, oldest entry first.
// rsp channel (valid/ready): one transfer per request with the match flag,
// the matched sub-second count, the queue fill after the request and the
// push overflow flag. csr_wr_en/csr_wr_data set the match window, 100 ns units.
// A push, or a match on an empty queue, is answered in the cycle after the
// request transfer. A match holds the queue in a row of cells and rotates it
// one place per examined entry; each entry goes through a three-stage window
// compare, oldest entry first, until a hit or the last held entry.
// No new request is taken while a match runs.
// The result sits in an output register; a new request is taken in the cycle
// that register is emptied. If rsp_ready stays low, the finished match waits
// with its queue update until the output register frees up.
// Reset empties the queue and loads the window with 0.05 s; the stored stamps
// themselves are not cleared.
`include "gps_subtime_matcher_macros.svh"

module gps_subtime_matcher (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_opcode,
   input  logic [gsm_pkg::SEC_W-1:0]           req_whole_seconds,
   input  logic [gsm_pkg::SUB_W-1:0]           req_sub_value,

   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_matched,
   output logic [gsm_pkg::SUB_W-1:0]           rsp_gps_sub_time,
   output logic [gsm_pkg::STORED_W-1:0]        rsp_stored_count,
   output logic                                rsp_overflow,

   input  logic                                csr_wr_en,
   input  logic [gsm_pkg::WIN_W-1:0]           csr_wr_data
);

   gsm_pkg::gsm_state_type state_ff, state_in;
   gsm_pkg::gsm_count_type count_ff, count_in;
   gsm_pkg::gsm_count_type scan_ff, scan_in;
   logic [gsm_pkg::WIN_W-1:0] window_ff, window_in;
   logic [gsm_pkg::SEC_W-1:0] ev_sec_ff, ev_sec_in;
   gsm_pkg::gsm_event_type    ev_subs_ff, ev_subs_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_matched_ff, rsp_matched_in;
   logic [gsm_pkg::SUB_W-1:0]     rsp_sub_ff, rsp_sub_in;
   gsm_pkg::gsm_stored_type       rsp_stored_ff, rsp_stored_in;
   logic                          rsp_ovf_ff, rsp_ovf_in;

   logic                          slot_free;
   logic                          req_fire;
   logic                          queue_full;
   logic                          last_entry;
   logic                          hit;
   logic                          rsp_load;
   gsm_pkg::gsm_count_type        scan_next;
   gsm_pkg::gsm_chain_ctrl_type   chain_ctrl;
   gsm_pkg::gsm_entry_type        push_entry;
   gsm_pkg::gsm_entry_type        cells [gsm_pkg::QUEUE_DEPTH];

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign req_fire   = req_valid && req_ready;
   assign queue_full = (count_ff == gsm_pkg::gsm_count_type'(gsm_pkg::QUEUE_DEPTH));
   assign scan_next  = scan_ff + gsm_pkg::gsm_count_type'(1);
   assign last_entry = (scan_next == count_ff);
   assign push_entry = '{sec: req_whole_seconds, sub: req_sub_value};

   // Row of cells: cell 0 is the oldest entry.
   for (genvar i = 0; i < gsm_pkg::QUEUE_DEPTH; i++) begin : g_cell
      gsm_cell u_cell (
         .clock      (clock),
         .ctrl       (chain_ctrl),
         .cell_index (gsm_pkg::gsm_index_type'(i)),
         .load_entry (push_entry),
         .wrap_entry (cells[0]),
         .next_entry (cells[(i == gsm_pkg::QUEUE_DEPTH - 1) ? i : i + 1]),
         .entry_out  (cells[i])
      );
   end

   gsm_window u_window (
      .clock      (clock),
      .head_entry (cells[0]),
      .event_sec  (ev_sec_ff),
      .event_subs (ev_subs_ff),
      .window     (window_ff),
      .hit        (hit)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gsm_pkg::GSM_IDLE: begin
            if (req_fire && (req_opcode == gsm_pkg::GSM_OP_MATCH) && (count_ff != '0)) begin
               state_in = gsm_pkg::GSM_DIFF;
            end
         end
         gsm_pkg::GSM_DIFF: state_in = gsm_pkg::GSM_PROD;
         gsm_pkg::GSM_PROD: state_in = gsm_pkg::GSM_DECIDE;
         gsm_pkg::GSM_DECIDE: begin
            if (hit || last_entry) begin
               if (slot_free) begin
                  state_in = gsm_pkg::GSM_IDLE;
               end
            end else begin
               state_in = gsm_pkg::GSM_DIFF;
            end
         end
         default: state_in = gsm_pkg::GSM_IDLE;
      endcase
   end

   // Outputs and datapath control.
   always_comb begin
      req_ready         = 1'b0;
      chain_ctrl        = '0;
      chain_ctrl.count  = count_ff;
      count_in          = count_ff;
      scan_in           = scan_ff;
      ev_sec_in         = ev_sec_ff;
      ev_subs_in        = ev_subs_ff;
      rsp_load          = 1'b0;
      rsp_matched_in    = 1'b0;
      rsp_sub_in        = '0;
      rsp_ovf_in        = 1'b0;
      case (state_ff)
         gsm_pkg::GSM_IDLE: begin
            req_ready = slot_free;
            if (req_fire) begin
               if (req_opcode == gsm_pkg::GSM_OP_PUSH) begin
                  rsp_load = 1'b1;
                  if (queue_full) begin
                     rsp_ovf_in = 1'b1;
                  end else begin
                     chain_ctrl.load = 1'b1;
                     count_in = count_ff + gsm_pkg::gsm_count_type'(1);
                  end
               end else begin
                  // microseconds * 10 = (us << 3) + (us << 1)
                  ev_sec_in  = req_whole_seconds;
                  ev_subs_in = (gsm_pkg::gsm_event_type'(req_sub_value) << 3)
                             + (gsm_pkg::gsm_event_type'(req_sub_value) << 1);
                  scan_in    = '0;
                  if (count_ff == '0) begin
                     rsp_load = 1'b1;
                  end
               end
            end
         end
         gsm_pkg::GSM_DECIDE: begin
            if (hit) begin
               if (slot_free) begin
                  // drop the matched entry and everything older
                  chain_ctrl.shift = 1'b1;
                  count_in         = count_ff - scan_next;
                  rsp_load         = 1'b1;
                  rsp_matched_in   = 1'b1;
                  rsp_sub_in       = cells[0].sub;
               end
            end else if (last_entry) begin
               if (slot_free) begin
                  // final rotation restores the original order
                  chain_ctrl.rotate = 1'b1;
                  rsp_load          = 1'b1;
               end
            end else begin
               chain_ctrl.rotate = 1'b1;
               scan_in           = scan_next;
            end
         end
         default: begin
         end
      endcase
      rsp_stored_in = gsm_pkg::gsm_stored_type'(count_in);
   end

   always_comb begin
      window_in = csr_wr_en ? csr_wr_data : window_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gsm_pkg::GSM_IDLE;
         count_ff     <= '0;
         scan_ff      <= '0;
         window_ff    <= gsm_pkg::WINDOW_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_ff      <= scan_in;
         window_ff    <= window_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_sec_ff  <= ev_sec_in;
      ev_subs_ff <= ev_subs_in;
      if (rsp_load) begin
         rsp_matched_ff <= rsp_matched_in;
         rsp_sub_ff     <= rsp_sub_in;
         rsp_stored_ff  <= rsp_stored_in;
         rsp_ovf_ff     <= rsp_ovf_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_matched      = rsp_matched_ff;
   assign rsp_gps_sub_time = rsp_sub_ff;
   assign rsp_stored_count = rsp_stored_ff;
   assign rsp_overflow     = rsp_ovf_ff;

   `GSM_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= gsm_pkg::gsm_count_type'(gsm_pkg::QUEUE_DEPTH))
   `GSM_ASSERT_SAME(a_scan_in_queue, state_ff != gsm_pkg::GSM_IDLE, scan_ff < count_ff)
   `GSM_ASSERT_NEXT(a_full_push_drops, req_fire && (req_opcode == gsm_pkg::GSM_OP_PUSH) && queue_full, rsp_valid_ff && rsp_overflow && (count_ff == $past(count_ff)))
   `GSM_ASSERT_NEXT(a_match_drops_entries, (state_ff == gsm_pkg::GSM_DECIDE) && hit && slot_free, rsp_matched && (count_ff < $past(count_ff)))

endmodule

// ===== rtl/gsm_cell.sv =====
module gsm_cell (
   input  logic                        clock,
   input  gsm_pkg::gsm_chain_ctrl_type ctrl,
   input  gsm_pkg::gsm_index_type      cell_index,
   input  gsm_pkg::gsm_entry_type      load_entry,
   input  gsm_pkg::gsm_entry_type      wrap_entry,
   input  gsm_pkg::gsm_entry_type      next_entry,
   output gsm_pkg::gsm_entry_type      entry_out
);

   gsm_pkg::gsm_entry_type entry_ff;
   gsm_pkg::gsm_entry_type entry_in;
   gsm_pkg::gsm_count_type my_pos;
   logic                   is_tail;

   assign my_pos  = gsm_pkg::gsm_count_type'(cell_index);
   // last occupied cell takes the head entry during a rotation
   assign is_tail = (ctrl.count == my_pos + gsm_pkg::gsm_count_type'(1));

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.load) begin
         if (ctrl.count == my_pos) begin
            entry_in = load_entry;
         end
      end else if (ctrl.rotate) begin
         entry_in = is_tail ? wrap_entry : next_entry;
      end else if (ctrl.shift) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_out = entry_ff;

endmodule

// ===== rtl/gsm_window.sv =====
module gsm_window (
   input  logic                                clock,
   input  gsm_pkg::gsm_entry_type              head_entry,
   input  logic [gsm_pkg::SEC_W-1:0]           event_sec,
   input  gsm_pkg::gsm_event_type              event_subs,
   input  logic [gsm_pkg::WIN_W-1:0]           window,
   output logic                                hit
);

   logic [gsm_pkg::SEC_W:0] sec_diff;

   logic                  near_ff, near_in;
   logic signed [5:0]     sec_small_ff, sec_small_in;
   gsm_pkg::gsm_diff_type diff_ff, diff_in;

   logic                  near2_ff, near2_in;
   gsm_pkg::gsm_diff_type prod_ff, prod_in;
   gsm_pkg::gsm_diff_type diff2_ff, diff2_in;

   gsm_pkg::gsm_off_type  offset;
   gsm_pkg::gsm_off_type  win_s;

   // Stage 1: second difference and sub-second difference.
   // Only second differences in -8..31 can land inside a 24-bit window.
   always_comb begin
      sec_diff     = {1'b0, head_entry.sec} - {1'b0, event_sec};
      near_in      = (sec_diff[gsm_pkg::SEC_W:5] == '0) || (&sec_diff[gsm_pkg::SEC_W:3]);
      sec_small_in = $signed(sec_diff[5:0]);
      diff_in      = gsm_pkg::gsm_diff_type'(event_subs)
                   - gsm_pkg::gsm_diff_type'(head_entry.sub);
   end

   // Stage 2: scale the second difference to 100 ns units.
   always_comb begin
      near2_in = near_ff;
      diff2_in = diff_ff;
      prod_in  = gsm_pkg::gsm_diff_type'(sec_small_ff)
               * gsm_pkg::gsm_diff_type'(gsm_pkg::SUBS_PER_SECOND);
   end

   always_ff @(posedge clock) begin
      near_ff      <= near_in;
      sec_small_ff <= sec_small_in;
      diff_ff      <= diff_in;
      near2_ff     <= near2_in;
      prod_ff      <= prod_in;
      diff2_ff     <= diff2_in;
   end

   // Stage 3: |offset| < window, as two parallel compares.
   always_comb begin
      offset = gsm_pkg::gsm_off_type'(diff2_ff) - gsm_pkg::gsm_off_type'(prod_ff);
      win_s  = gsm_pkg::gsm_off_type'($signed({1'b0, window}));
      hit    = near2_ff && (offset < win_s) && (offset > -win_s);
   end

endmodule

// ===== tb/gps_subtime_matcher_checker.sv =====
`timescale 1ns / 1ps

module gps_subtime_matcher_checker (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic                         req_opcode,
   input  logic [gsm_pkg::SEC_W-1:0]    req_whole_seconds,
   input  logic [gsm_pkg::SUB_W-1:0]    req_sub_value,

   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic                         rsp_matched,
   input  logic [gsm_pkg::SUB_W-1:0]    rsp_gps_sub_time,
   input  logic [gsm_pkg::STORED_W-1:0] rsp_stored_count,
   input  logic                         rsp_overflow,

   input  logic                         csr_wr_en,
   input  logic [gsm_pkg::WIN_W-1:0]    csr_wr_data,

   output int                           error_count,
   output int                           waiting_results,
   output int                           hit_count,
   output int                           overflow_count
);
   import gsm_pkg::*;

   localparam int REPORT_LIMIT = 10;
   localparam int SUBS_PER_US  = 10;

   typedef struct packed {
      logic                matched;
      logic [SUB_W-1:0]    gps_sub_time;
      logic [STORED_W-1:0] stored_count;
      logic                overflow;
   } stamp_reply_type;

   gsm_entry_type    held_stamps[$];
   stamp_reply_type  replies_due[$];
   logic [WIN_W-1:0] match_window = WINDOW_RESET;
   stamp_reply_type  due_reply;
   stamp_reply_type  seen_reply;
   int               mismatches = 0;
   int               hits = 0;
   int               refused = 0;

   // offset in exact 100 ns units, wide enough for any pair of 32-bit seconds
   function automatic logic within_window(input gsm_entry_type stamp,
                                          input logic [SEC_W-1:0] ev_sec,
                                          input logic [SUB_W-1:0] ev_us);
      longint gap;
      gap = longint'(ev_us) * SUBS_PER_US - longint'(stamp.sub)
            - (longint'(stamp.sec) - longint'(ev_sec)) * SUBS_PER_SECOND;
      if (gap < 0)
         gap = -gap;
      return gap < longint'(match_window);
   endfunction

   function automatic stamp_reply_type apply_request(input logic op,
                                                     input logic [SEC_W-1:0] sec,
                                                     input logic [SUB_W-1:0] sub);
      stamp_reply_type reply;
      gsm_entry_type   stamp;
      int              hit;
      int              idx;
      reply = '0;
      hit = -1;
      if (op == GSM_OP_PUSH) begin
         if (held_stamps.size() >= QUEUE_DEPTH) begin
            reply.overflow = 1'b1;
         end else begin
            stamp = {sec, sub};
            held_stamps.push_back(stamp);
         end
      end else begin
         for (idx = 0; idx < held_stamps.size() && hit < 0; idx++) begin
            stamp = held_stamps[idx];
            if (within_window(stamp, sec, sub))
               hit = idx;
         end
         if (hit >= 0) begin
            stamp = held_stamps[hit];
            reply.matched = 1'b1;
            reply.gps_sub_time = stamp.sub;
            // drop the hit and everything older
            repeat (hit + 1)
               stamp = held_stamps.pop_front();
         end
      end
      reply.stored_count = STORED_W'(held_stamps.size());
      return reply;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         held_stamps.delete();
         replies_due.delete();
         match_window = WINDOW_RESET;
      end else begin
         if (csr_wr_en)
            match_window = csr_wr_data;
         if (rsp_valid && rsp_ready) begin
            seen_reply = {rsp_matched, rsp_gps_sub_time, rsp_stored_count, rsp_overflow};
            if (replies_due.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("%0t: unexpected result: matched %0d sub %0d count %0d ovf %0d",
                           $time, rsp_matched, rsp_gps_sub_time, rsp_stored_count,
                           rsp_overflow);
            end else begin
               due_reply = replies_due.pop_front();
               if (due_reply.matched)
                  hits++;
               if (due_reply.overflow)
                  refused++;
               if (seen_reply !== due_reply) begin
                  mismatches++;
                  if (mismatches <= REPORT_LIMIT) begin
                     $display("%0t: mismatch (expected/actual): matched %0d/%0d sub %0d/%0d",
                              $time, due_reply.matched, seen_reply.matched,
                              due_reply.gps_sub_time, seen_reply.gps_sub_time);
                     $display("   count %0d/%0d ovf %0d/%0d",
                              due_reply.stored_count, seen_reply.stored_count,
                              due_reply.overflow, seen_reply.overflow);
                  end
               end
            end
         end
         if (req_valid && req_ready)
            replies_due.push_back(apply_request(req_opcode, req_whole_seconds,
                                                req_sub_value));
      end
      waiting_results <= replies_due.size();
      error_count <= mismatches;
      hit_count <= hits;
      overflow_count <= refused;
   end

endmodule

// ===== tb/gps_subtime_matcher_tb.sv =====
`timescale 1ns / 1ps

module gps_subtime_matcher_tb;
   import gsm_pkg::*;

   localparam int RUN_LIMIT     = 3_000_000;
   localparam int IDLE_PCT      = 23;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 8;
   localparam int FILL_EXTRA    = 6;
   localparam int QUIET_PUSHES  = 400;
   localparam int PHASE_ITEMS   = 30;
   localparam int RECENT        = 8;
   localparam int SUBS_PER_US   = 10;
   localparam logic [WIN_W-1:0] WINDOW_MAX  = 24'd10_000_000;
   localparam logic [WIN_W-1:0] WINDOW_FULL = '1;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_opcode = GSM_OP_PUSH;
   logic [SEC_W-1:0]    req_whole_seconds = '0;
   logic [SUB_W-1:0]    req_sub_value = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_matched;
   logic [SUB_W-1:0]    rsp_gps_sub_time;
   logic [STORED_W-1:0] rsp_stored_count;
   logic                rsp_overflow;
   logic                csr_wr_en = 1'b0;
   logic [WIN_W-1:0]    csr_wr_data = '0;

   int error_count;
   int waiting_results;
   int hit_count;
   int overflow_count;

   int               cycle_count = 0;
   int               req_idle_pct = IDLE_PCT;
   int               rsp_idle_pct = IDLE_PCT;
   int               hold_requests = 0;
   int               holds_taken = 0;
   int               hold_left = 0;
   int               pushes_sent = 0;
   int               matches_sent = 0;
   int               windows_set = 0;
   logic [WIN_W-1:0] window_now = WINDOW_RESET;
   longint           gps_now;
   gsm_entry_type    pushed_stamps[$];

   gps_subtime_matcher dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_whole_seconds (req_whole_seconds),
      .req_sub_value     (req_sub_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_matched       (rsp_matched),
      .rsp_gps_sub_time  (rsp_gps_sub_time),
      .rsp_stored_count  (rsp_stored_count),
      .rsp_overflow      (rsp_overflow),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   gps_subtime_matcher_checker stamp_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_whole_seconds (req_whole_seconds),
      .req_sub_value     (req_sub_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_matched       (rsp_matched),
      .rsp_gps_sub_time  (rsp_gps_sub_time),
      .rsp_stored_count  (rsp_stored_count),
      .rsp_overflow      (rsp_overflow),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .error_count       (error_count),
      .waiting_results   (waiting_results),
      .hit_count         (hit_count),
      .overflow_count    (overflow_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < RUN_LIMIT)
         @(posedge clock) cycle_count++;
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               waiting_results);
      $display("gps_subtime_matcher verification failed");
      $finish;
   end

   // result side: random stalls, plus a long hold-off whenever one is requested
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_taken != hold_requests) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         holds_taken <= holds_taken + 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic offer_item(input logic op, input logic [SEC_W-1:0] sec,
                             input logic [SUB_W-1:0] sub);
      gsm_entry_type stamp;
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(99) < req_idle_pct);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_whole_seconds <= sec;
      req_sub_value <= sub;
      do
         @(posedge clock);
      while (!req_ready);
      if (op == GSM_OP_PUSH) begin
         stamp = {sec, sub};
         pushed_stamps.push_back(stamp);
         pushes_sent++;
      end else begin
         matches_sent++;
      end
   endtask

   task automatic push_next_stamp(input longint step);
      gps_now += step;
      offer_item(GSM_OP_PUSH, SEC_W'(gps_now / SUBS_PER_SECOND),
                 SUB_W'(gps_now % SUBS_PER_SECOND));
   endtask

   // event time scattered around a stamp, a little past the window on both sides
   function automatic void aim_event(input gsm_entry_type target,
                                     output logic [SEC_W-1:0] ev_sec,
                                     output logic [SUB_W-1:0] ev_us);
      longint span;
      longint ev_time;
      span = longint'(window_now) + longint'(window_now) / 8 + 40;
      ev_time = longint'(target.sec) * SUBS_PER_SECOND + longint'(target.sub)
                + longint'($urandom_range(0, int'(2 * span))) - span;
      if (ev_time < 0)
         ev_time = 0;
      ev_sec = SEC_W'(ev_time / SUBS_PER_SECOND);
      ev_us = SUB_W'((ev_time % SUBS_PER_SECOND) / SUBS_PER_US);
   endfunction

   task automatic match_stamp(input int index);
      gsm_entry_type    target;
      logic [SEC_W-1:0] sec;
      logic [SUB_W-1:0] sub;
      target = pushed_stamps[index];
      aim_event(target, sec, sub);
      offer_item(GSM_OP_MATCH, sec, sub);
   endtask

   task automatic drain_results;
      req_valid <= 1'b0;
      do
         @(posedge clock);
      while (waiting_results != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_window(input logic [WIN_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      window_now = value;
      windows_set++;
   endtask

   task automatic run_directed;
      offer_item(GSM_OP_MATCH, 32'd0, 24'd0);             // empty queue
      offer_item(GSM_OP_PUSH, 32'd0, 24'd0);
      offer_item(GSM_OP_PUSH, 32'hFFFF_FFFF, 24'd9_999_999);
      offer_item(GSM_OP_PUSH, 32'hFFFF_FFFF, 24'hFF_FFFF);
      offer_item(GSM_OP_PUSH, 32'd100, 24'd5_000_000);
      offer_item(GSM_OP_MATCH, 32'd100, 24'd500_000);     // hit newest, drop all
      offer_item(GSM_OP_PUSH, 32'd200, 24'd1_000_000);
      offer_item(GSM_OP_PUSH, 32'd200, 24'd2_000_000);
      offer_item(GSM_OP_PUSH, 32'd200, 24'd3_000_000);
      offer_item(GSM_OP_MATCH, 32'd200, 24'd249_999);     // hit second, drop first two
      offer_item(GSM_OP_MATCH, 32'd200, 24'd350_000);     // offset equals window
      offer_item(GSM_OP_MATCH, 32'd200, 24'd349_999);
      offer_item(GSM_OP_PUSH, 32'd301, 24'd200_000);
      offer_item(GSM_OP_MATCH, 32'd300, 24'd990_000);     // across a whole-second boundary
      offer_item(GSM_OP_PUSH, 32'd400, 24'd9_999_999);
      offer_item(GSM_OP_MATCH, 32'd400, 24'hFF_FFFF);     // microseconds out of range
      offer_item(GSM_OP_MATCH, 32'd401, 24'd0);
      offer_item(GSM_OP_PUSH, 32'd0, 24'd0);
      offer_item(GSM_OP_MATCH, 32'hFFFF_FFFF, 24'd0);     // far future event
      offer_item(GSM_OP_MATCH, 32'd0, 24'd0);
   endtask

   task automatic run_fill;
      int fill_start;
      fill_start = pushed_stamps.size();
      req_idle_pct = 0;
      rsp_idle_pct <= 0;
      // overrun the queue so the last pushes are refused
      for (int k = 0; k < QUEUE_DEPTH + FILL_EXTRA; k++) begin
         if (k == QUIET_PUSHES) begin
            req_idle_pct = IDLE_PCT;
            rsp_idle_pct <= IDLE_PCT;
         end
         push_next_stamp(SUBS_PER_SECOND + longint'($urandom_range(0, 4000)) - 2000);
      end
      offer_item(GSM_OP_MATCH, SEC_W'(gps_now / SUBS_PER_SECOND) + 32'd1_000_000, '0);
      match_stamp(fill_start + 500);
      push_next_stamp(SUBS_PER_SECOND);
      match_stamp(fill_start + 1000);
   endtask

   task automatic run_traffic(input int n_items);
      int               pick;
      int               depth;
      logic [SEC_W-1:0] sec;
      logic [SUB_W-1:0] sub;
      repeat (n_items) begin
         pick = $urandom_range(99);
         if (pick < 50) begin
            push_next_stamp(longint'($urandom_range(200_000, 15_000_000)));
         end else if (pick < 58) begin
            offer_item(GSM_OP_PUSH, SEC_W'($urandom), SUB_W'($urandom_range(0, 24'hFF_FFFF)));
         end else if (pick < 90 && pushed_stamps.size() != 0) begin
            depth = (pushed_stamps.size() < RECENT) ? pushed_stamps.size() : RECENT;
            match_stamp(pushed_stamps.size() - 1 - $urandom_range(0, depth - 1));
         end else begin
            if ($urandom_range(3) == 0)
               sec = SEC_W'($urandom);
            else
               sec = SEC_W'(gps_now / SUBS_PER_SECOND) + SEC_W'($urandom_range(0, 4)) - 2;
            if ($urandom_range(3) == 0)
               sub = SUB_W'($urandom_range(0, 24'hFF_FFFF));
            else
               sub = SUB_W'($urandom_range(0, 999_999));
            offer_item(GSM_OP_MATCH, sec, sub);
         end
      end
   endtask

   initial begin
      gps_now = longint'($urandom_range(1000, 2_000_000_000)) * SUBS_PER_SECOND;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      drain_results();

      write_window(WINDOW_MAX);
      run_fill();
      drain_results();

      write_window('0);
      run_traffic(PHASE_ITEMS);
      drain_results();

      // stall the result side long enough to back up the request side
      write_window(WINDOW_FULL);
      hold_requests <= hold_requests + 1;
      run_traffic(PHASE_ITEMS);
      drain_results();

      write_window(WIN_W'(1));
      run_traffic(PHASE_ITEMS);
      drain_results();

      write_window(WIN_W'($urandom_range(1000, 10_000_000)));
      run_traffic(PHASE_ITEMS);
      drain_results();

      $display("covered %0d pushes and %0d matches under %0d window settings",
               pushes_sent, matches_sent, windows_set + 1);
      $display("%0d matches hit, %0d pushes refused on a full queue, %0d mismatches",
               hit_count, overflow_count, error_count);
      if (error_count == 0 && waiting_results == 0)
         $display("gps_subtime_matcher verification clean");
      else
         $display("gps_subtime_matcher verification failed");
      $finish;
   end

endmodule

// ===== gps_subtime_matcher.f =====
+incdir+rtl
rtl/gsm_pkg.sv
rtl/gsm_cell.sv
rtl/gsm_window.sv
rtl/gps_subtime_matcher.sv
tb/gps_subtime_matcher_checker.sv
tb/gps_subtime_matcher_tb.sv
